// ===== rtl/pbs_pkg.sv =====
// Package with the word types, register indexes and phase codes of the pump bank sequencer.
`default_nettype none

package pbs_pkg;

  typedef struct packed {
    logic [16:0] time_secs;
    logic [2:0]  current_day;
  } in_word_t;

  typedef struct packed {
    logic [2:0] pump_index;
    logic [5:0] pwm_value;
    logic       running;
    logic       last;
  } out_word_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] CFG_START_SECS   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SKIP         = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SELECTED_DAY = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PWM_INITIAL  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PWM_STEADY   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_RUN_TICKS    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_INTER_DELAY  = 3'd6;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_BUSY  = 3'b010,
    PH_DONE  = 3'b100
  } phase_t;

endpackage

`default_nettype wire

// ===== rtl/pump_bank_sequencer.sv =====
// Top level of the pump bank sequencer: tick evaluation, ramp emitter and result register.
`default_nettype none

// Each accepted input word is one tick. The tick updates the watering state at once and
// may start a job of PWM result words that a single result register sends one word per
// cycle while out_stall is low. A tick that causes no result or one result lets the next
// tick in as soon as the result register is free, so ticks can arrive back to back. A tick
// that starts a pump's ramp keeps in_stall high until its last word goes into the result
// register: the ramp has pwm_initial - pwm_steady + 1 words, 64 at most. The result
// register can hold a finished word while the next tick is accepted. Configuration
// writes are always ready and must only be made while the block is idle.
module pump_bank_sequencer
  import pbs_pkg::*;
#(
  parameter int NUM_PUMPS = 4,
  parameter int PWM_BITS  = 6
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire in_word_t            in_data,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      out_word_t           out_data,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  localparam logic [5:0] PwmMask = 6'((1 << PWM_BITS) - 1);
  localparam logic [3:0] LastPump = 4'(NUM_PUMPS);

  logic [16:0] start_secs_r;
  logic        skip_r;
  logic [2:0]  selected_day_r;
  logic [5:0]  pwm_initial_r;
  logic [5:0]  pwm_steady_r;
  logic [7:0]  run_ticks_r;
  logic [7:0]  inter_delay_r;

  logic        running_r, running_nxt;
  logic [2:0]  pump_index_r, pump_index_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  busy_count_r, busy_count_nxt;
  logic [7:0]  gap_count_r, gap_count_nxt;

  logic        job_active_r;
  logic [2:0]  job_pump_r;
  logic [5:0]  job_val_r;
  logic [5:0]  job_end_r;
  logic        job_run_r;

  logic        new_job;
  logic [5:0]  new_val;
  logic [5:0]  new_end;

  logic        out_valid_r;
  out_word_t   out_data_r;

  logic        out_free;
  logic        job_last;
  logic        job_done_now;
  logic        in_acc;
  logic        hit;
  logic        run_now;
  logic [7:0]  busy_inc;
  logic [8:0]  gap_limit;
  logic [3:0]  pump_inc;

  assign out_free     = !out_valid_r || !out_stall;
  assign job_last     = job_val_r == job_end_r;
  assign job_done_now = job_active_r && out_free && job_last;
  assign in_stall     = job_active_r && !job_done_now;
  assign in_acc       = in_valid && !in_stall;
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  assign hit = (in_data.time_secs == start_secs_r) ||
               ((start_secs_r != 17'd0) && (in_data.time_secs == start_secs_r - 17'd1));
  assign run_now   = running_r ||
                     (!skip_r && (selected_day_r == in_data.current_day) && hit);
  assign busy_inc  = busy_count_r + 8'd1;
  assign gap_limit = {1'b0, run_ticks_r} + {1'b0, inter_delay_r};
  assign pump_inc  = {1'b0, pump_index_r} + 4'd1;

  always_comb begin
    running_nxt    = run_now;
    pump_index_nxt = pump_index_r;
    phase_nxt      = phase_r;
    busy_count_nxt = busy_count_r;
    gap_count_nxt  = gap_count_r;
    new_job        = 1'b0;
    new_val        = pwm_initial_r;
    new_end        = pwm_steady_r;
    if (run_now) begin
      unique case (phase_r)
        PH_START: begin
          new_job   = pwm_initial_r >= pwm_steady_r;
          phase_nxt = PH_BUSY;
        end
        PH_BUSY: begin
          busy_count_nxt = busy_inc;
          if (busy_inc > run_ticks_r) begin
            phase_nxt = PH_DONE;
          end
        end
        PH_DONE: begin
          new_job        = 1'b1;
          new_val        = 6'd0;
          new_end        = 6'd0;
          busy_count_nxt = 8'd0;
          phase_nxt      = PH_START;
        end
        default: begin
          phase_nxt = PH_START;
        end
      endcase
      gap_count_nxt = gap_count_r + 8'd1;
      if ({1'b0, gap_count_r} >= gap_limit) begin
        gap_count_nxt = 8'd0;
        if (pump_inc >= LastPump) begin
          running_nxt    = 1'b0;
          pump_index_nxt = 3'd0;
        end else begin
          pump_index_nxt = pump_inc[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_secs_r   <= 17'd0;
      skip_r         <= 1'b0;
      selected_day_r <= 3'd0;
      pwm_initial_r  <= 6'd63 & PwmMask;
      pwm_steady_r   <= 6'd32 & PwmMask;
      run_ticks_r    <= 8'd30;
      inter_delay_r  <= 8'd10;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_SECS:   start_secs_r   <= cfg_wdata;
        CFG_SKIP:         skip_r         <= cfg_wdata[0];
        CFG_SELECTED_DAY: selected_day_r <= cfg_wdata[2:0];
        CFG_PWM_INITIAL:  pwm_initial_r  <= cfg_wdata[5:0] & PwmMask;
        CFG_PWM_STEADY:   pwm_steady_r   <= cfg_wdata[5:0] & PwmMask;
        CFG_RUN_TICKS:    run_ticks_r    <= cfg_wdata[7:0];
        CFG_INTER_DELAY:  inter_delay_r  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r    <= 1'b0;
      pump_index_r <= 3'd0;
      phase_r      <= PH_START;
      busy_count_r <= 8'd0;
      gap_count_r  <= 8'd0;
    end else if (in_acc) begin
      running_r    <= running_nxt;
      pump_index_r <= pump_index_nxt;
      phase_r      <= phase_nxt;
      busy_count_r <= busy_count_nxt;
      gap_count_r  <= gap_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_active_r <= 1'b0;
    end else if (in_acc && new_job) begin
      job_active_r <= 1'b1;
    end else if (job_done_now) begin
      job_active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && new_job) begin
      job_pump_r <= pump_index_r;
      job_val_r  <= new_val;
      job_end_r  <= new_end;
      job_run_r  <= running_nxt;
    end else if (job_active_r && out_free && !job_last) begin
      job_val_r <= job_val_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= job_active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && job_active_r) begin
      out_data_r.pump_index <= job_pump_r;
      out_data_r.pwm_value  <= job_val_r;
      out_data_r.running    <= job_run_r;
      out_data_r.last       <= job_last;
    end
  end

`ifndef SYNTHESIS
  a_ramp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    job_active_r |-> job_val_r >= job_end_r)
    else $error("Ramp value passed its end value.");

  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !out_data_r.last |=> out_valid_r)
    else $error("Gap inside the words of one tick.");

  a_idle_pump: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> pump_index_r == 3'd0)
    else $error("Pump index not zero while idle.");

  a_pump_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pump_index_r} < LastPump)
    else $error("Pump index beyond the last pump.");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the pump bank sequencer with a tick predictor and a word scoreboard.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pbs_pkg::*;

  localparam int NUM_PUMPS = 4;
  localparam int PWM_BITS  = 6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 3'd7;

  typedef struct {
    logic [16:0] start_secs;
    logic        skip;
    logic [2:0]  day;
    logic [5:0]  pwm_initial;
    logic [5:0]  pwm_steady;
    logic [7:0]  run_ticks;
    logic [7:0]  inter_delay;
  } settings_t;

  class pwm_schedule;
    logic [16:0] start_secs;
    logic        skip;
    logic [2:0]  sel_day;
    logic [5:0]  pwm_initial;
    logic [5:0]  pwm_steady;
    logic [7:0]  run_ticks;
    logic [7:0]  inter_delay;
    logic [5:0]  pwm_mask;
    logic        running;
    int          pump_index;
    phase_t      phase;
    logic [7:0]  busy_count;
    logic [7:0]  gap_count;
    out_word_t   pending_words[$];
    int          ticks;
    int          words_checked;
    int          starts;
    int          failures;

    function new();
      pwm_mask      = 6'((1 << PWM_BITS) - 1);
      start_secs    = '0;
      skip          = 1'b0;
      sel_day       = '0;
      pwm_initial   = 6'd63 & pwm_mask;
      pwm_steady    = 6'd32 & pwm_mask;
      run_ticks     = 8'd30;
      inter_delay   = 8'd10;
      running       = 1'b0;
      pump_index    = 0;
      phase         = PH_START;
      busy_count    = '0;
      gap_count     = '0;
      ticks         = 0;
      words_checked = 0;
      starts        = 0;
      failures      = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_START_SECS:   start_secs = data[16:0];
        CFG_SKIP:         skip = data[0];
        CFG_SELECTED_DAY: sel_day = data[2:0];
        CFG_PWM_INITIAL:  pwm_initial = data[5:0] & pwm_mask;
        CFG_PWM_STEADY:   pwm_steady = data[5:0] & pwm_mask;
        CFG_RUN_TICKS:    run_ticks = data[7:0];
        CFG_INTER_DELAY:  inter_delay = data[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    function void take_tick(in_word_t w);
      logic [5:0] vals[$];
      logic [7:0] old_gap;
      out_word_t  word;
      int         pump;
      int         v;
      ticks++;
      if (!skip && sel_day == w.current_day &&
          (w.time_secs == start_secs ||
           (start_secs != 0 && w.time_secs == start_secs - 17'd1))) begin
        if (!running) starts++;
        running = 1'b1;
      end
      if (!running) return;
      pump = pump_index;
      case (phase)
        PH_START: begin
          if (pwm_initial >= pwm_steady) begin
            v = pwm_initial;
            vals.push_back(6'(v) & pwm_mask);
            while (v > pwm_steady) begin
              v--;
              vals.push_back(6'(v) & pwm_mask);
            end
          end
          phase = PH_BUSY;
        end
        PH_BUSY: begin
          busy_count = busy_count + 8'd1;
          if (busy_count > run_ticks) phase = PH_DONE;
        end
        PH_DONE: begin
          vals.push_back(6'd0);
          busy_count = '0;
          phase = PH_START;
        end
        default: ;
      endcase
      old_gap = gap_count;
      gap_count = gap_count + 8'd1;
      if (int'(old_gap) >= int'(run_ticks) + int'(inter_delay)) begin
        pump_index++;
        if (pump_index >= NUM_PUMPS) begin
          running = 1'b0;
          pump_index = 0;
        end
        gap_count = '0;
      end
      foreach (vals[k]) begin
        word.pump_index = 3'(pump);
        word.pwm_value  = vals[k];
        word.running    = running;
        word.last       = (k == vals.size() - 1);
        pending_words.push_back(word);
      end
    endfunction

    function void match_word(out_word_t got);
      out_word_t exp;
      if (pending_words.size() == 0) begin
        $error("Unexpected PWM word: pump %0d pwm %0d", got.pump_index, got.pwm_value);
        failures++;
        return;
      end
      exp = pending_words.pop_front();
      words_checked++;
      if (got.pump_index !== exp.pump_index) begin
        $error("pump_index: expected %0d, got %0d", exp.pump_index, got.pump_index);
        failures++;
      end
      if (got.pwm_value !== exp.pwm_value) begin
        $error("pwm_value: expected %0d, got %0d", exp.pwm_value, got.pwm_value);
        failures++;
      end
      if (got.running !== exp.running) begin
        $error("running: expected %0b, got %0b", exp.running, got.running);
        failures++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0b, got %0b", exp.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_word_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  int          idle_pct = 36;
  int unsigned hold_asked = 0;
  int          settings_loaded = 0;

  pwm_schedule sched;

  pump_bank_sequencer #(
    .NUM_PUMPS(NUM_PUMPS),
    .PWM_BITS (PWM_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Run timed out.");
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sched.take_tick(in_data);
      if (out_valid && !out_stall) sched.match_word(out_data);
    end
  end

  initial begin
    int unsigned served;
    int          hold;
    served = 0;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != served) begin
        served++;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  function automatic in_word_t tick_at(int unsigned t, int unsigned d);
    in_word_t w;
    w.time_secs   = 17'(t);
    w.current_day = 3'(d);
    return w;
  endfunction

  task automatic send_tick(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_settings(settings_t s, bit poke_spare);
    logic [CfgIdxW-1:0]  idx[8];
    logic [CfgDataW-1:0] val[8];
    int                  n;
    int                  i;
    idx = '{CFG_START_SECS, CFG_SKIP, CFG_SELECTED_DAY, CFG_PWM_INITIAL,
            CFG_PWM_STEADY, CFG_RUN_TICKS, CFG_INTER_DELAY, CFG_SPARE};
    val = '{s.start_secs, 17'(s.skip), 17'(s.day), 17'(s.pwm_initial),
            17'(s.pwm_steady), 17'(s.run_ticks), 17'(s.inter_delay),
            17'($urandom_range(131071))};
    n = poke_spare ? 8 : 7;
    for (i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      do @(posedge clk); while (!cfg_ready);
      sched.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sched.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    settings_t   s;
    in_word_t    w;
    int unsigned secs;
    int          r;
    int          ph;
    int          k;
    sched = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // A start time of zero must not also match the last second of the day.
    s = '{start_secs: 17'd0, skip: 1'b0, day: 3'd0, pwm_initial: 6'd63, pwm_steady: 6'd0,
          run_ticks: 8'd2, inter_delay: 8'd1};
    load_settings(s, 1'b0);
    send_tick(tick_at(86399, 0));
    send_tick(tick_at(0, 7));
    send_tick(tick_at(0, 0));
    send_tick(tick_at(1, 0));
    send_tick(tick_at(0, 0));
    send_tick(tick_at(3, 0));
    send_tick(tick_at(4, 0));
    settle();

    // Inverted ramp, zero pump time and zero delay, start one second early.
    s = '{start_secs: 17'd86400, skip: 1'b0, day: 3'd7, pwm_initial: 6'd5, pwm_steady: 6'd9,
          run_ticks: 8'd0, inter_delay: 8'd0};
    load_settings(s, 1'b0);
    send_tick(tick_at(86399, 7));
    send_tick(tick_at(0, 7));
    send_tick(tick_at(1, 7));
    send_tick(tick_at(86399, 6));
    send_tick(tick_at(86399, 7));
    send_tick(tick_at(3, 7));
    send_tick(tick_at(4, 7));
    send_tick(tick_at(5, 7));
    settle();

    s = '{start_secs: 17'd100, skip: 1'b1, day: 3'd3, pwm_initial: 6'd63, pwm_steady: 6'd63,
          run_ticks: 8'd1, inter_delay: 8'd0};
    load_settings(s, 1'b0);
    send_tick(tick_at(100, 3));
    send_tick(tick_at(99, 3));
    settle();
    s.skip = 1'b0;
    load_settings(s, 1'b1);
    send_tick(tick_at(99, 3));
    send_tick(tick_at(100, 3));
    send_tick(tick_at(101, 3));
    settle();

    // The gap sum here exceeds eight bits.
    s = '{start_secs: 17'd5, skip: 1'b0, day: 3'd2, pwm_initial: 6'd40, pwm_steady: 6'd38,
          run_ticks: 8'd255, inter_delay: 8'd255};
    load_settings(s, 1'b1);
    send_tick(tick_at(4, 2));
    send_tick(tick_at(5, 2));
    send_tick(tick_at(6, 2));
    send_tick(tick_at(7, 2));
    send_tick(tick_at(8, 2));
    settle();

    for (ph = 0; ph < 12; ph++) begin
      s.start_secs = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 17'd0 : 17'd86400)
                                              : 17'($urandom_range(86400));
      s.skip = ($urandom_range(7) == 0);
      s.day = 3'($urandom_range(7));
      s.pwm_steady = 6'($urandom_range(63));
      if ($urandom_range(9) == 0) begin
        s.pwm_initial = 6'($urandom_range(63));
      end else begin
        r = int'(s.pwm_steady) + $urandom_range(4);
        s.pwm_initial = 6'((r > 63) ? 63 : r);
      end
      s.run_ticks = ($urandom_range(7) == 0) ? 8'($urandom_range(254)) : 8'($urandom_range(5));
      s.inter_delay = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(5));
      if (ph == 2) begin
        s.pwm_initial = 6'd63;
        s.pwm_steady = 6'd0;
        s.skip = 1'b0;
      end
      idle_pct = (ph == 6) ? 0 : 36;
      load_settings(s, ph == 5);
      if (ph == 2) hold_asked++;
      secs = $urandom_range(86399);
      for (k = 0; k < 28; k++) begin
        r = $urandom_range(9);
        if (r < 2) begin
          if (s.start_secs == 17'd86400) secs = 86399;
          else if (s.start_secs != 0 && $urandom_range(1)) secs = s.start_secs - 1;
          else secs = s.start_secs;
          w = tick_at(secs, s.day);
        end else if (r < 8) begin
          secs = (secs >= 86399) ? 0 : secs + 1;
          w = tick_at(secs, ($urandom_range(3) == 0) ? $urandom_range(7) : s.day);
        end else begin
          w = tick_at($urandom_range(86399), $urandom_range(7));
        end
        send_tick(w);
      end
      settle();
    end

    $display("Run covered %0d ticks under %0d register settings with %0d watering starts.",
             sched.ticks, settings_loaded, sched.starts);
    $display("%0d PWM words were compared field by field.", sched.words_checked);
    if (sched.failures == 0 && sched.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/pbs_pkg.sv
rtl/pump_bank_sequencer.sv
sim/tb.sv
